[hdl/utf8_stream_decoder_core_defines.svh]
// assertion macros used by the bound checker module u8sd_checker
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/u8sd_pkg.sv]
package u8sd_pkg;

  localparam int CpW  = 21;
  localparam int LenW = 3;
  localparam int CntW = 16;

  localparam logic [7:0] ByteZero   = 8'h00;
  localparam logic [7:0] ContBase   = 8'h80;
  localparam logic [7:0] Lead2Base  = 8'hC0;
  localparam logic [7:0] Lead3Base  = 8'hE0;
  localparam logic [7:0] Lead4Base  = 8'hF0;
  localparam logic [7:0] BadHigh    = 8'hF8;
  localparam logic [7:0] ContMask   = 8'h3F;
  localparam logic [7:0] Lead2Mask  = 8'h1F;
  localparam logic [7:0] Lead3Mask  = 8'h0F;
  localparam logic [7:0] Lead4Mask  = 8'h07;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] Len1    = 3'd1;
  localparam logic [LenW-1:0] Len2    = 3'd2;
  localparam logic [LenW-1:0] Len3    = 3'd3;
  localparam logic [LenW-1:0] Len4    = 3'd4;

  localparam logic [1:0] RemNone = 2'd0;
  localparam logic [1:0] RemOne  = 2'd1;
  localparam logic [1:0] RemTwo  = 2'd2;
  localparam logic [1:0] RemThree = 2'd3;

  typedef struct packed {
    logic [CpW-1:0]  acc;
    logic [1:0]      remain;
    logic [LenW-1:0] len;
    logic [CntW-1:0] chars;
    logic [CntW-1:0] bytes;
  } state_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [LenW-1:0] seq_length;
    logic [CntW-1:0] char_count;
    logic [CntW-1:0] byte_count;
    logic            end_of_string;
    logic            bad_lead;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (&v) ? v : CntW'(v + 1'b1);
  endfunction

  function automatic logic [CpW-1:0] lead_bits(input logic [7:0] b, input logic [7:0] mask);
    return {{(CpW-8){1'b0}}, b & mask};
  endfunction

endpackage

[hdl/u8sd_if.sv]
interface u8sd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface u8sd_result_if;
  logic                     valid;
  logic                     ready;
  logic [u8sd_pkg::CpW-1:0]  code_point;
  logic [u8sd_pkg::LenW-1:0] seq_length;
  logic [u8sd_pkg::CntW-1:0] char_count;
  logic [u8sd_pkg::CntW-1:0] byte_count;
  logic                     end_of_string;
  logic                     bad_lead;

  modport source (output valid, output code_point, output seq_length, output char_count,
                  output byte_count, output end_of_string, output bad_lead, input ready);
  modport sink (input valid, input code_point, input seq_length, input char_count,
                input byte_count, input end_of_string, input bad_lead, output ready);
endinterface

[hdl/u8sd_step.sv]
module u8sd_step (
  input  u8sd_pkg::state_t  cur,
  input  logic [7:0]        byte_in,
  output u8sd_pkg::state_t  nxt,
  output u8sd_pkg::result_t res,
  output logic              emit
);

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '0;
    if (cur.remain != u8sd_pkg::RemNone) begin
      // continuation, top bits not checked
      nxt.acc    = {cur.acc[u8sd_pkg::CpW-7:0], byte_in[5:0] & u8sd_pkg::ContMask[5:0]};
      nxt.remain = cur.remain - 2'd1;
      nxt.bytes  = u8sd_pkg::sat_inc(cur.bytes);
      if (cur.remain == u8sd_pkg::RemOne) begin
        nxt.chars      = u8sd_pkg::sat_inc(cur.chars);
        emit           = 1'b1;
        res.code_point = nxt.acc;
        res.seq_length = cur.len;
      end
    end else if (byte_in == u8sd_pkg::ByteZero) begin
      emit              = 1'b1;
      res.end_of_string = 1'b1;
      nxt.chars         = '0;
      nxt.bytes         = '0;
      nxt.acc           = '0;
      nxt.len           = u8sd_pkg::LenNone;
    end else begin
      nxt.bytes = u8sd_pkg::sat_inc(cur.bytes);
      if (byte_in < u8sd_pkg::ContBase) begin
        nxt.acc        = u8sd_pkg::lead_bits(byte_in, 8'hFF);
        nxt.len        = u8sd_pkg::Len1;
        nxt.chars      = u8sd_pkg::sat_inc(cur.chars);
        emit           = 1'b1;
        res.code_point = nxt.acc;
        res.seq_length = u8sd_pkg::Len1;
      end else if (byte_in < u8sd_pkg::Lead2Base || byte_in >= u8sd_pkg::BadHigh) begin
        nxt.acc      = '0;
        nxt.len      = u8sd_pkg::LenNone;
        emit         = 1'b1;
        res.bad_lead = 1'b1;
      end else if (byte_in < u8sd_pkg::Lead3Base) begin
        nxt.acc    = u8sd_pkg::lead_bits(byte_in, u8sd_pkg::Lead2Mask);
        nxt.len    = u8sd_pkg::Len2;
        nxt.remain = u8sd_pkg::RemOne;
      end else if (byte_in < u8sd_pkg::Lead4Base) begin
        nxt.acc    = u8sd_pkg::lead_bits(byte_in, u8sd_pkg::Lead3Mask);
        nxt.len    = u8sd_pkg::Len3;
        nxt.remain = u8sd_pkg::RemTwo;
      end else begin
        nxt.acc    = u8sd_pkg::lead_bits(byte_in, u8sd_pkg::Lead4Mask);
        nxt.len    = u8sd_pkg::Len4;
        nxt.remain = u8sd_pkg::RemThree;
      end
    end
    res.char_count = nxt.chars;
    res.byte_count = nxt.bytes;
    if (res.end_of_string) begin
      res.char_count = cur.chars;
      res.byte_count = cur.bytes;
    end
  end

endmodule

[hdl/utf8_stream_decoder_core.sv]
// channel  | dir | payload
// stream   | in  | byte_in
// result   | out | code_point, seq_length, char_count, byte_count, end_of_string, bad_lead
//
// one byte per cycle unless the result side stalls; a byte's result lands in the result register
// path: input register, one decode step, result register
// rst (synchronous) clears the open sequence, both counts and all valid flags
// a stalled result holds the decode stage, which in turn holds the stream side
module utf8_stream_decoder_core (
  input logic                clk,
  input logic                rst,
  u8sd_byte_if.sink          stream,
  u8sd_result_if.source      result
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  u8sd_pkg::state_t  st;
  u8sd_pkg::state_t  st_next;
  u8sd_pkg::result_t step_res;
  logic              step_emit;
  logic              out_valid;
  u8sd_pkg::result_t out_res;
  logic              out_free;
  logic              s1_go;

  assign out_free     = !out_valid || result.ready;
  assign s1_go        = s1_valid && out_free;
  assign stream.ready = !s1_valid || s1_go;

  u8sd_step u_step (
    .cur     (st),
    .byte_in (s1_byte),
    .nxt     (st_next),
    .res     (step_res),
    .emit    (step_emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (stream.ready) begin
        s1_valid <= stream.valid;
      end
      if (s1_go) begin
        st <= st_next;
      end
      if (out_free) begin
        out_valid <= s1_go && step_emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_byte <= stream.byte_in;
    end
    if (s1_go && step_emit) begin
      out_res <= step_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.code_point    = out_res.code_point;
  assign result.seq_length    = out_res.seq_length;
  assign result.char_count    = out_res.char_count;
  assign result.byte_count    = out_res.byte_count;
  assign result.end_of_string = out_res.end_of_string;
  assign result.bad_lead      = out_res.bad_lead;

endmodule

[hdl/u8sd_checker.sv]
`include "utf8_stream_decoder_core_defines.svh"

module u8sd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [u8sd_pkg::CpW-1:0]  code_point,
  input logic [u8sd_pkg::LenW-1:0] seq_length,
  input logic                      end_of_string,
  input logic                      bad_lead
);

  `U8SD_ASSERT_NEXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(seq_length), "stalled result changed")
  `U8SD_ASSERT_NOW(a_eos_clean, out_valid && end_of_string, code_point == '0 && seq_length == u8sd_pkg::LenNone && !bad_lead, "end result carries data")
  `U8SD_ASSERT_NOW(a_bad_clean, out_valid && bad_lead, code_point == '0 && seq_length == u8sd_pkg::LenNone && !end_of_string, "error result carries data")
  `U8SD_ASSERT_NOW(a_char_len, out_valid && !bad_lead && !end_of_string, seq_length == u8sd_pkg::Len1 || seq_length == u8sd_pkg::Len2 || seq_length == u8sd_pkg::Len3 || seq_length == u8sd_pkg::Len4, "character with bad length")

endmodule

bind utf8_stream_decoder_core u8sd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .code_point    (result.code_point),
  .seq_length    (result.seq_length),
  .end_of_string (result.end_of_string),
  .bad_lead      (result.bad_lead)
);

[bench/utf8_stream_decoder_core_checker.sv]
`timescale 1ns / 1ps

module utf8_stream_decoder_core_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_byte,
  input  logic                      res_valid,
  input  logic                      res_ready,
  input  logic [u8sd_pkg::CpW-1:0]  code_point,
  input  logic [u8sd_pkg::LenW-1:0] seq_length,
  input  logic [u8sd_pkg::CntW-1:0] char_count,
  input  logic [u8sd_pkg::CntW-1:0] byte_count,
  input  logic                      end_of_string,
  input  logic                      bad_lead,
  output int                        mismatches,
  output int                        awaiting
);

  logic [u8sd_pkg::CpW-1:0]  code_acc;
  logic [1:0]                cont_left;
  logic [u8sd_pkg::LenW-1:0] open_len;
  logic [u8sd_pkg::CntW-1:0] chars_so_far;
  logic [u8sd_pkg::CntW-1:0] bytes_so_far;
  u8sd_pkg::result_t         expected_chars[$];
  int                        err_total;

  function automatic logic [u8sd_pkg::CntW-1:0] count_up(input logic [u8sd_pkg::CntW-1:0] v);
    return (&v) ? v : u8sd_pkg::CntW'(v + 1'b1);
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    u8sd_pkg::result_t r;
    r = '0;
    if (cont_left != u8sd_pkg::RemNone) begin
      code_acc = {code_acc[u8sd_pkg::CpW-7:0], b[5:0] & u8sd_pkg::ContMask[5:0]};
      cont_left = cont_left - 1'b1;
      bytes_so_far = count_up(bytes_so_far);
      if (cont_left == u8sd_pkg::RemNone) begin
        chars_so_far = count_up(chars_so_far);
        r.code_point = code_acc;
        r.seq_length = open_len;
        r.char_count = chars_so_far;
        r.byte_count = bytes_so_far;
        expected_chars.push_back(r);
      end
    end else if (b == u8sd_pkg::ByteZero) begin
      r.end_of_string = 1'b1;
      r.char_count = chars_so_far;
      r.byte_count = bytes_so_far;
      expected_chars.push_back(r);
      chars_so_far = '0;
      bytes_so_far = '0;
      code_acc = '0;
      open_len = u8sd_pkg::LenNone;
    end else begin
      bytes_so_far = count_up(bytes_so_far);
      if (b < u8sd_pkg::ContBase) begin
        code_acc = u8sd_pkg::CpW'(b);
        open_len = u8sd_pkg::Len1;
        chars_so_far = count_up(chars_so_far);
        r.code_point = code_acc;
        r.seq_length = u8sd_pkg::Len1;
        r.char_count = chars_so_far;
        r.byte_count = bytes_so_far;
        expected_chars.push_back(r);
      end else if (b < u8sd_pkg::Lead2Base || b >= u8sd_pkg::BadHigh) begin
        code_acc = '0;
        open_len = u8sd_pkg::LenNone;
        r.bad_lead = 1'b1;
        r.char_count = chars_so_far;
        r.byte_count = bytes_so_far;
        expected_chars.push_back(r);
      end else if (b < u8sd_pkg::Lead3Base) begin
        code_acc = u8sd_pkg::CpW'(b & u8sd_pkg::Lead2Mask);
        open_len = u8sd_pkg::Len2;
        cont_left = u8sd_pkg::RemOne;
      end else if (b < u8sd_pkg::Lead4Base) begin
        code_acc = u8sd_pkg::CpW'(b & u8sd_pkg::Lead3Mask);
        open_len = u8sd_pkg::Len3;
        cont_left = u8sd_pkg::RemTwo;
      end else begin
        code_acc = u8sd_pkg::CpW'(b & u8sd_pkg::Lead4Mask);
        open_len = u8sd_pkg::Len4;
        cont_left = u8sd_pkg::RemThree;
      end
    end
  endtask

  always @(posedge clk) begin
    u8sd_pkg::result_t got;
    u8sd_pkg::result_t want;
    if (rst) begin
      code_acc = '0;
      cont_left = u8sd_pkg::RemNone;
      open_len = u8sd_pkg::LenNone;
      chars_so_far = '0;
      bytes_so_far = '0;
      expected_chars.delete();
      err_total = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_byte);
      end
      if (res_valid && res_ready) begin
        got.code_point = code_point;
        got.seq_length = seq_length;
        got.char_count = char_count;
        got.byte_count = byte_count;
        got.end_of_string = end_of_string;
        got.bad_lead = bad_lead;
        if (expected_chars.size() == 0) begin
          err_total++;
          $display("%0t: unexpected result cp=%h len=%0d chars=%0d bytes=%0d eos=%b bad=%b",
                   $time, got.code_point, got.seq_length, got.char_count, got.byte_count,
                   got.end_of_string, got.bad_lead);
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            err_total++;
            $display("%0t: mismatch exp cp=%h len=%0d chars=%0d bytes=%0d eos=%b bad=%b",
                     $time, want.code_point, want.seq_length, want.char_count,
                     want.byte_count, want.end_of_string, want.bad_lead);
            $display("%0t:          got cp=%h len=%0d chars=%0d bytes=%0d eos=%b bad=%b",
                     $time, got.code_point, got.seq_length, got.char_count,
                     got.byte_count, got.end_of_string, got.bad_lead);
          end
        end
      end
    end
    mismatches <= err_total;
    awaiting <= expected_chars.size();
  end

endmodule

[bench/utf8_stream_decoder_core_tb.sv]
`timescale 1ns / 1ps

module utf8_stream_decoder_core_tb;

  localparam int IdleLimit = 5000;
  localparam int RandomBytes = 1450;

  typedef enum logic [1:0] {RxFree, RxCoin, RxMostly, RxPulse} rx_mode_t;

  logic clk;
  logic rst;

  u8sd_byte_if   stream_if();
  u8sd_result_if result_if();

  logic [7:0] tx_bytes[$];
  int         burst_left;
  int         gap_left;
  int         fail_total;
  int         pending_total;

  utf8_stream_decoder_core u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  utf8_stream_decoder_core_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (stream_if.valid),
    .in_ready      (stream_if.ready),
    .in_byte       (stream_if.byte_in),
    .res_valid     (result_if.valid),
    .res_ready     (result_if.ready),
    .code_point    (result_if.code_point),
    .seq_length    (result_if.seq_length),
    .char_count    (result_if.char_count),
    .byte_count    (result_if.byte_count),
    .end_of_string (result_if.end_of_string),
    .bad_lead      (result_if.bad_lead),
    .mismatches    (fail_total),
    .awaiting      (pending_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    stream_if.valid = 1'b0;
    stream_if.byte_in = 8'h00;
    result_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'(u8sd_pkg::ContBase + $urandom_range(0, 63));
  endfunction

  task automatic add_char();
    case ($urandom_range(0, 3))
      0: tx_bytes.push_back(8'($urandom_range(1, 127)));
      1: begin
        tx_bytes.push_back(8'(u8sd_pkg::Lead2Base + $urandom_range(0, 31)));
        tx_bytes.push_back(cont_byte());
      end
      2: begin
        tx_bytes.push_back(8'(u8sd_pkg::Lead3Base + $urandom_range(0, 15)));
        repeat (2) tx_bytes.push_back(cont_byte());
      end
      default: begin
        tx_bytes.push_back(8'(u8sd_pkg::Lead4Base + $urandom_range(0, 7)));
        repeat (3) tx_bytes.push_back(cont_byte());
      end
    endcase
  endtask

  initial begin
    int target;
    // empty string, ascii bounds, shortest and longest sequences
    tx_bytes = '{8'h00, 8'h01, 8'h7F, 8'hC0, 8'h80, 8'hE0, 8'h80, 8'h80,
                 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h80, 8'h80, 8'h80,
                 8'hF7, 8'hFF, 8'hFF, 8'hFF};
    // bad leads, zero as continuation, end of string
    tx_bytes.push_back(8'h80);
    tx_bytes.push_back(8'hBF);
    tx_bytes.push_back(8'hF8);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'hC5);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'h00);
    target = tx_bytes.size() + RandomBytes;
    while (tx_bytes.size() < target) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 24)) add_char();
        if ($urandom_range(0, 9) != 0) tx_bytes.push_back(u8sd_pkg::ByteZero);
      end
    end
    tx_bytes.push_back(u8sd_pkg::ByteZero);
    tx_bytes.push_back(8'hF8);
    tx_bytes.push_back(u8sd_pkg::ByteZero);
    tx_bytes.push_back(8'h41);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(u8sd_pkg::ByteZero);
  end

  // sender in bursts, valid held until the request is taken
  initial begin
    burst_left = 1;
    gap_left = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else begin
      if (stream_if.valid && stream_if.ready) begin
        tx_bytes.delete(0);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!(stream_if.valid && !stream_if.ready)) begin
        if (gap_left > 0) begin
          stream_if.valid <= 1'b0;
          gap_left--;
        end else if (tx_bytes.size() != 0) begin
          stream_if.valid <= 1'b1;
          stream_if.byte_in <= tx_bytes[0];
        end else begin
          stream_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off early in the random part
  always @(posedge clk) begin
    static int       rx_cycle = 0;
    static int       hold_left = 0;
    static int       mode_left = 0;
    static rx_mode_t rx_mode = RxFree;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 300) hold_left = 400;
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          RxFree:   result_if.ready <= 1'b1;
          RxCoin:   result_if.ready <= 1'($urandom_range(0, 1));
          RxMostly: result_if.ready <= ($urandom_range(0, 3) != 0);
          default:  result_if.ready <= rx_cycle[2];
        endcase
      end
    end
  end

  // watchdog on cycles with no request taken on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    do @(posedge clk); while (rst || tx_bytes.size() != 0 || stream_if.valid);
    while (pending_total != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_total == 0 && pending_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
